// ----- src/ntc_pkg.sv -----
`default_nettype none
package ntc_pkg;

	localparam logic [1:0] CLS_SIGNED   = 2'd0;
	localparam logic [1:0] CLS_UNSIGNED = 2'd1;
	localparam logic [1:0] CLS_FLOAT    = 2'd2;
	localparam logic [1:0] CLS_NONE     = 2'd3;

	localparam logic [3:0] KIND_F32 = 4'd8;
	localparam logic [3:0] KIND_F64 = 4'd9;

	localparam logic [63:0] F64_SIGN  = 64'h8000_0000_0000_0000;
	localparam logic [63:0] F64_QUIET = 64'h0008_0000_0000_0000;
	localparam logic [63:0] F64_INF   = 64'h7FF0_0000_0000_0000;

	// operation chosen for the middle stage
	localparam logic [2:0] OP_PASS = 3'd0;
	localparam logic [2:0] OP_I2F  = 3'd1;
	localparam logic [2:0] OP_U2F  = 3'd2;
	localparam logic [2:0] OP_F2I  = 3'd3;
	localparam logic [2:0] OP_F2U  = 3'd4;

	function automatic logic [1:0] kind_class(input logic [3:0] k);
		logic [1:0] c;
		if (k <= 4'd3) c = CLS_SIGNED;
		else if (k <= 4'd7) c = CLS_UNSIGNED;
		else if (k <= 4'd9) c = CLS_FLOAT;
		else c = CLS_NONE;
		return c;
	endfunction

	function automatic logic [63:0] int_mask(input logic [3:0] k);
		logic [63:0] m;
		case (k[1:0])
			2'd0: m = 64'h0000_0000_0000_00FF;
			2'd1: m = 64'h0000_0000_0000_FFFF;
			2'd2: m = 64'h0000_0000_FFFF_FFFF;
			default: m = '1;
		endcase
		return m;
	endfunction

	// index of the highest set bit of a nonzero word, leading-one detect
	function automatic logic [5:0] msb_pos(input logic [63:0] v);
		logic [5:0] p;
		p = '0;
		for (int i = 0; i < 64; i++) begin
			if (v[i]) p = 6'(i);
		end
		return p;
	endfunction

	typedef struct packed {
		logic       valid;
		logic [1:0] tcls;
		logic [3:0] tkind;
		logic [2:0] op;
	} ctl_t;

endpackage
`default_nettype wire

// ----- src/numeric_type_converter.sv -----
`default_nettype none
// Converts one value between i8..i64, u8..u64, binary32 and binary64 per request.
// A request is taken whenever start is high (busy is always low); its result
// appears on result_bits with done high after the registers of three stages:
// widen, class conversion, narrow, one result per cycle. The
// receiver cannot stall, so done must be sampled in that cycle.
module numeric_type_converter (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [63:0] source_bits,
	input  wire logic [3:0]  source_kind,
	input  wire logic [3:0]  target_kind,
	output logic             done,
	output logic [63:0]      result_bits
);
	ntc_pkg::ctl_t ctl_s1, ctl_s2;
	logic [63:0]   val_s1, val_s2;

	assign busy = 1'b0;

	ntc_widen u_widen (
		.clk, .arst_n, .in_valid(start), .source_bits, .source_kind, .target_kind,
		.ctl_s1, .val_s1
	);

	ntc_cross u_cross (
		.clk, .arst_n, .ctl_s1, .val_s1, .ctl_s2, .val_s2
	);

	ntc_narrow u_narrow (
		.clk, .arst_n, .ctl_s2, .val_s2, .done_s3(done), .val_s3(result_bits)
	);
endmodule
`default_nettype wire

// ----- src/ntc_widen.sv -----
`default_nettype none
// stage 1: widen the source to int64, uint64 or binary64
module ntc_widen (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	input  wire logic [63:0]      source_bits,
	input  wire logic [3:0]       source_kind,
	input  wire logic [3:0]       target_kind,
	output ntc_pkg::ctl_t         ctl_s1,
	output logic [63:0]           val_s1
);
	logic [1:0]  sc, tc;
	logic [63:0] m, v, f32w;
	logic [2:0]  op;
	logic [7:0]  e32;
	logic [22:0] m32;
	logic [4:0]  lz;
	logic [22:0] mn;

	always_comb begin
		sc = ntc_pkg::kind_class(source_kind);
		tc = ntc_pkg::kind_class(target_kind);
		e32 = source_bits[30:23];
		m32 = source_bits[22:0];
		// subnormal normalize
		lz = 5'd22 - 5'(ntc_pkg::msb_pos({41'd0, m32}));
		mn = m32 << (lz + 5'd1);
		if (e32 == 8'hFF) begin
			f32w = {source_bits[31], 11'h7FF, 52'd0};
			if (m32 != '0) f32w = f32w | ntc_pkg::F64_QUIET | ({41'd0, m32} << 29);
		end else if (e32 == '0) begin
			if (m32 == '0) f32w = {source_bits[31], 63'd0};
			else f32w = {source_bits[31], 11'(11'd896 - {6'd0, lz}), mn, 29'd0};
		end else begin
			f32w = {source_bits[31], 11'({3'd0, e32} + 11'd896), m32, 29'd0};
		end
		m = ntc_pkg::int_mask(source_kind);
		v = '0;
		case (sc)
			ntc_pkg::CLS_FLOAT:
				v = (source_kind == ntc_pkg::KIND_F32) ? f32w : source_bits;
			ntc_pkg::CLS_SIGNED: begin
				v = source_bits & m;
				if (m != '1 && (v & ((m >> 1) + 64'd1)) != '0) v = v | ~m;
			end
			ntc_pkg::CLS_UNSIGNED: v = source_bits & m;
			default: v = '0;
		endcase
		op = ntc_pkg::OP_PASS;
		if (tc == ntc_pkg::CLS_FLOAT && sc == ntc_pkg::CLS_SIGNED) op = ntc_pkg::OP_I2F;
		else if (tc == ntc_pkg::CLS_FLOAT && sc == ntc_pkg::CLS_UNSIGNED)
			op = ntc_pkg::OP_U2F;
		else if (tc == ntc_pkg::CLS_SIGNED && sc == ntc_pkg::CLS_FLOAT)
			op = ntc_pkg::OP_F2I;
		else if (tc == ntc_pkg::CLS_UNSIGNED && sc == ntc_pkg::CLS_FLOAT)
			op = ntc_pkg::OP_F2U;
	end

	// stage 1 control register
	// an undefined source leaves the widened value zero and skips narrowing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1.valid <= in_valid;
			ctl_s1.tcls  <= (sc == ntc_pkg::CLS_NONE) ? ntc_pkg::CLS_NONE : tc;
			ctl_s1.tkind <= (sc == ntc_pkg::CLS_NONE) ? 4'hF : target_kind;
			ctl_s1.op    <= (sc == ntc_pkg::CLS_NONE) ? ntc_pkg::OP_PASS : op;
		end
	end

	always_ff @(posedge clk) begin
		val_s1 <= v;
	end
endmodule
`default_nettype wire

// ----- src/ntc_cross.sv -----
`default_nettype none
// stage 2: convert between integer and binary64 classes
module ntc_cross (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  ntc_pkg::ctl_t         ctl_s1,
	input  wire logic [63:0]      val_s1,
	output ntc_pkg::ctl_t         ctl_s2,
	output logic [63:0]           val_s2
);
	logic        neg;
	logic [63:0] mag, q, rem, half, fv, sig, fmag, fi;
	logic [5:0]  p, sh;
	logic [10:0] e;
	logic        nan, rup;
	logic signed [12:0] ex;

	always_comb begin
		// integer to binary64
		neg = (ctl_s1.op == ntc_pkg::OP_I2F) && val_s1[63];
		mag = neg ? (64'd0 - val_s1) : val_s1;
		p = ntc_pkg::msb_pos(mag);
		sh = (p > 6'd52) ? (p - 6'd52) : 6'd0;
		q = mag >> sh;
		rem = mag & ((64'd1 << sh) - 64'd1);
		half = (sh == '0) ? 64'd0 : (64'd1 << (sh - 6'd1));
		rup = (sh != '0) && (rem > half || (rem == half && q[0]));
		if (mag == '0) fv = '0;
		else if (p <= 6'd52)
			fv = ({53'd0, 11'(p) + 11'd1022} << 52) + (mag << (6'd52 - p));
		else
			fv = ({53'd0, 11'(p) + 11'd1022} << 52) + q + {63'd0, rup};
		if (neg) fv = fv | ntc_pkg::F64_SIGN;

		// binary64 to integer
		e = val_s1[62:52];
		ex = 13'(e) - 13'sd1023;
		nan = (e == 11'h7FF) && (val_s1[51:0] != '0);
		sig = {11'd0, 1'b1, val_s1[51:0]};
		if (ex >= 13'sd52) fmag = sig << 6'(ex - 13'sd52);
		else if (ex >= 0) fmag = sig >> 6'(13'sd52 - ex);
		else fmag = '0;
		fi = '0;
		if (ctl_s1.op == ntc_pkg::OP_F2I) begin
			if (nan || ex < 0) fi = '0;
			else if (ex >= 13'sd63)
				fi = val_s1[63] ? ntc_pkg::F64_SIGN : ~ntc_pkg::F64_SIGN;
			else fi = val_s1[63] ? (64'd0 - fmag) : fmag;
		end else begin
			if (nan || ex < 0 || val_s1[63]) fi = '0;
			else if (ex >= 13'sd64) fi = '1;
			else fi = fmag;
		end
	end

	// stage 2 control register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
		end else begin
			ctl_s2 <= ctl_s1;
		end
	end

	always_ff @(posedge clk) begin
		case (ctl_s1.op)
			ntc_pkg::OP_I2F, ntc_pkg::OP_U2F: val_s2 <= fv;
			ntc_pkg::OP_F2I, ntc_pkg::OP_F2U: val_s2 <= fi;
			default: val_s2 <= val_s1;
		endcase
	end
endmodule
`default_nettype wire

// ----- src/ntc_narrow.sv -----
`default_nettype none
// stage 3: narrow to the target type
module ntc_narrow (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  ntc_pkg::ctl_t         ctl_s2,
	input  wire logic [63:0]      val_s2,
	output logic                  done_s3,
	output logic [63:0]           val_s3
);
	logic [63:0] f32, sig, q, rem, half, bits;
	logic [10:0] e;
	logic signed [12:0] ef;
	logic [6:0]  shift;
	logic        rup;

	always_comb begin
		e = val_s2[62:52];
		ef = 13'(e) - 13'sd896;
		sig = {11'd0, 1'b1, val_s2[51:0]};
		shift = (ef >= 13'sd1) ? 7'd29 : 7'(13'sd30 - ef);
		if (shift > 7'd63) shift = 7'd63;
		q = sig >> shift;
		rem = sig & ((64'd1 << shift) - 64'd1);
		half = 64'd1 << (shift - 7'd1);
		rup = rem > half || (rem == half && q[0]);
		q = q + {63'd0, rup};
		if (ef >= 13'sd1) begin
			bits = ({51'd0, 13'(ef - 13'sd1)} << 23) + q;
			if (bits >= 64'h7F80_0000) bits = 64'h7F80_0000;
		end else bits = q;
		if (e == 11'h7FF) begin
			f32 = (val_s2[51:0] == '0) ? 64'h7F80_0000
				: (64'h7FC0_0000 | {41'd0, val_s2[51:29]});
		end else if (e == '0) f32 = '0;
		else if (ef >= 13'sd255) f32 = 64'h7F80_0000;
		else if (13'sd30 - ef >= 13'sd55 && ef < 13'sd1) f32 = '0;
		else f32 = bits;
		f32[31] = val_s2[63];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s3 <= 1'b0;
		end else begin
			done_s3 <= ctl_s2.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl_s2.tcls == ntc_pkg::CLS_SIGNED || ctl_s2.tcls == ntc_pkg::CLS_UNSIGNED)
			val_s3 <= val_s2 & ntc_pkg::int_mask(ctl_s2.tkind);
		else if (ctl_s2.tkind == ntc_pkg::KIND_F32)
			val_s3 <= f32;
		else
			val_s3 <= val_s2;
	end
endmodule
`default_nettype wire
